/* design/vertex_index_deduplicator_defines.svh */
// ---------------------------------------------------------------------------
// vertex index deduplicator assertion macros
// concurrent check wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef VERTEX_INDEX_DEDUPLICATOR_DEFINES_SVH
`define VERTEX_INDEX_DEDUPLICATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vid assertion failed");
// next-cycle implication
`define VID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vid assertion failed");
`else
`define VID_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VID_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/vid_pkg.sv */
// ---------------------------------------------------------------------------
// vid_pkg
// shared types and codes of the vertex index deduplicator
// ---------------------------------------------------------------------------
package vid_pkg;

	localparam int POS_BITS            = 10;
	localparam int POSITIONS_DEF       = 1024;
	localparam int MAP_ENTRIES_DEF     = 256;
	localparam int ATTR_INDEX_BITS_DEF = 16;
	localparam int FLAT_BITS_DEF       = 16;

	localparam logic [1:0] MODE_UNSEEN = 2'd0;
	localparam logic [1:0] MODE_CACHED = 2'd1;
	localparam logic [1:0] MODE_SHARED = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_POS_RANGE = 2'd1;
	localparam logic [1:0] ST_MAP_FULL  = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	typedef enum logic [1:0] {
		SRC_NONE  = 2'd0,
		SRC_TABLE = 2'd1,
		SRC_MAP   = 2'd2,
		SRC_NEXT  = 2'd3
	} src_t;

	typedef struct packed {
		logic       cap;
		logic       clr_wr;
		logic       tbl_wr_cached;
		logic       tbl_wr_shared;
		logic       map_ins_old;
		logic       map_ins_new;
		logic       scan_start;
		logic       scan_run;
		logic       res_ld;
		src_t       res_src;
		logic [1:0] res_status;
		logic       res_new;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       pos_oor;
		logic [1:0] mode;
		logic       tbl_match;
		logic       room1;
		logic       room2;
		logic       exhausted;
		logic       scan_hit;
		logic       scan_end;
	} stat_t;

endpackage

/* design/vid_ctrl.sv */
// ---------------------------------------------------------------------------
// vid_ctrl
// sequencer: table clear, lookup, map scan and inserts
// ---------------------------------------------------------------------------
`include "vertex_index_deduplicator_defines.svh"

module vid_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  vid_pkg::stat_t stat,
	output vid_pkg::cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_READ    = 7'b0000100,
		S_EVAL    = 7'b0001000,
		S_SCAN    = 7'b0010000,
		S_INS_OLD = 7'b0100000,
		S_INS_NEW = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				priority if (stat.pos_oor) begin
					cmd.res_ld     = 1'b1;
					cmd.res_status = vid_pkg::ST_POS_RANGE;
					state_d        = S_IDLE;
				end else if (stat.mode == vid_pkg::MODE_CACHED && stat.tbl_match) begin
					cmd.res_ld  = 1'b1;
					cmd.res_src = vid_pkg::SRC_TABLE;
					state_d     = S_IDLE;
				end else if (stat.mode == vid_pkg::MODE_CACHED) begin
					priority if (!stat.room2) begin
						cmd.res_ld     = 1'b1;
						cmd.res_status = vid_pkg::ST_MAP_FULL;
						state_d        = S_IDLE;
					end else if (stat.exhausted) begin
						cmd.res_ld     = 1'b1;
						cmd.res_status = vid_pkg::ST_EXHAUSTED;
						state_d        = S_IDLE;
					end else begin
						state_d = S_INS_OLD;
					end
				end else if (stat.mode == vid_pkg::MODE_SHARED) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
					if (stat.exhausted) begin
						cmd.res_status = vid_pkg::ST_EXHAUSTED;
					end else begin
						cmd.tbl_wr_cached = 1'b1;
						cmd.res_src       = vid_pkg::SRC_NEXT;
						cmd.res_new       = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				priority if (stat.scan_hit) begin
					cmd.res_ld  = 1'b1;
					cmd.res_src = vid_pkg::SRC_MAP;
					state_d     = S_IDLE;
				end else if (stat.scan_end) begin
					priority if (!stat.room1) begin
						cmd.res_ld     = 1'b1;
						cmd.res_status = vid_pkg::ST_MAP_FULL;
						state_d        = S_IDLE;
					end else if (stat.exhausted) begin
						cmd.res_ld     = 1'b1;
						cmd.res_status = vid_pkg::ST_EXHAUSTED;
						state_d        = S_IDLE;
					end else begin
						state_d = S_INS_NEW;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_INS_OLD: begin
				cmd.map_ins_old = 1'b1;
				state_d         = S_INS_NEW;
			end
			S_INS_NEW: begin
				cmd.map_ins_new   = 1'b1;
				cmd.tbl_wr_shared = 1'b1;
				cmd.res_ld        = 1'b1;
				cmd.res_src       = vid_pkg::SRC_NEXT;
				cmd.res_new       = 1'b1;
				state_d           = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	`VID_ASSERT_NEXT(a_res_to_idle, clk, arst_n, cmd.res_ld, state_q == S_IDLE)
	`VID_ASSERT_NEXT(a_old_then_new, clk, arst_n, state_q == S_INS_OLD, state_q == S_INS_NEW)
	`VID_ASSERT_NEXT(a_accept_reads, clk, arst_n, start && !busy, state_q == S_READ)

endmodule

/* design/vid_dpath.sv */
// ---------------------------------------------------------------------------
// vid_dpath
// position table, attribute map, counters and result registers
// ---------------------------------------------------------------------------
`include "vertex_index_deduplicator_defines.svh"

module vid_dpath #(
	parameter int POSITIONS       = vid_pkg::POSITIONS_DEF,
	parameter int MAP_ENTRIES     = vid_pkg::MAP_ENTRIES_DEF,
	parameter int ATTR_INDEX_BITS = vid_pkg::ATTR_INDEX_BITS_DEF,
	parameter int FLAT_BITS       = vid_pkg::FLAT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vid_pkg::cmd_t                cmd,
	output vid_pkg::stat_t               stat,
	input  logic [vid_pkg::POS_BITS-1:0] pos_idx,
	input  logic [ATTR_INDEX_BITS:0]     tex_idx,
	input  logic [ATTR_INDEX_BITS:0]     norm_idx,
	output logic                         done,
	output logic [FLAT_BITS-1:0]         flat_idx,
	output logic                         is_new,
	output logic [1:0]                   status
);

	localparam int PW     = vid_pkg::POS_BITS;
	localparam int AW     = ATTR_INDEX_BITS + 1;
	localparam int TBL_AW = $clog2(POSITIONS);
	localparam int TBL_W  = 2 + FLAT_BITS + 2 * AW;
	localparam int OW     = TBL_AW + PW + 1;
	localparam int MA_W   = $clog2(MAP_ENTRIES);
	localparam int MC_W   = $clog2(MAP_ENTRIES + 1);
	localparam int KEY_W  = PW + 2 * AW;

	// captured item
	logic [PW-1:0] pos_q;
	logic [AW-1:0] tc_q;
	logic [AW-1:0] nm_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pos_q <= pos_idx;
			tc_q  <= tex_idx;
			nm_q  <= norm_idx;
		end
	end

	logic [TBL_AW+PW-1:0] pos_ext;
	logic [TBL_AW-1:0]    pos_addr;
	assign pos_ext  = {{TBL_AW{1'b0}}, pos_q};
	assign pos_addr = pos_ext[TBL_AW-1:0];

	// control counters
	logic [TBL_AW-1:0]  clr_idx_q;
	logic [MC_W-1:0]    map_cnt_q;
	logic [MC_W-1:0]    scan_idx_q;
	logic               scan_vld_q;
	logic [FLAT_BITS:0] next_flat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			map_cnt_q   <= '0;
			scan_idx_q  <= '0;
			scan_vld_q  <= 1'b0;
			next_flat_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_idx_q <= clr_idx_q + TBL_AW'(1);
			end
			if (cmd.map_ins_old || cmd.map_ins_new) begin
				map_cnt_q <= map_cnt_q + MC_W'(1);
			end
			if (cmd.tbl_wr_cached || cmd.map_ins_new) begin
				next_flat_q <= next_flat_q + (FLAT_BITS + 1)'(1);
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				scan_vld_q <= 1'b0;
			end else if (cmd.scan_run) begin
				if (scan_idx_q != map_cnt_q) begin
					scan_idx_q <= scan_idx_q + MC_W'(1);
					scan_vld_q <= 1'b1;
				end else begin
					scan_vld_q <= 1'b0;
				end
			end
		end
	end

	// position table: mode, flat, texcoord, normal
	logic [TBL_W-1:0]  tbl_mem [POSITIONS];
	logic [TBL_W-1:0]  tbl_rd_q;
	logic [TBL_W-1:0]  tbl_wd;
	logic [TBL_AW-1:0] tbl_wa;
	logic              tbl_we;

	assign tbl_we = cmd.clr_wr || cmd.tbl_wr_cached || cmd.tbl_wr_shared;
	assign tbl_wa = cmd.clr_wr ? clr_idx_q : pos_addr;

	always_comb begin
		priority if (cmd.clr_wr) begin
			tbl_wd = {vid_pkg::MODE_UNSEEN, {(TBL_W - 2){1'b0}}};
		end else if (cmd.tbl_wr_cached) begin
			tbl_wd = {vid_pkg::MODE_CACHED, next_flat_q[FLAT_BITS-1:0], tc_q, nm_q};
		end else begin
			tbl_wd = {vid_pkg::MODE_SHARED, tbl_rd_q[TBL_W-3:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		tbl_rd_q <= tbl_mem[pos_addr];
	end

	logic [1:0]           tbl_mode;
	logic [FLAT_BITS-1:0] tbl_flat;
	logic [AW-1:0]        tbl_tc;
	logic [AW-1:0]        tbl_nm;
	assign tbl_mode = tbl_rd_q[TBL_W-1 -: 2];
	assign tbl_flat = tbl_rd_q[2*AW +: FLAT_BITS];
	assign tbl_tc   = tbl_rd_q[AW +: AW];
	assign tbl_nm   = tbl_rd_q[AW-1:0];

	// attribute map, filled in slot order and never freed
	logic [KEY_W-1:0]     key_mem [MAP_ENTRIES];
	logic [FLAT_BITS-1:0] val_mem [MAP_ENTRIES];
	logic [KEY_W-1:0]     key_rd_q;
	logic [FLAT_BITS-1:0] val_rd_q;
	logic [KEY_W-1:0]     key_new;
	logic [KEY_W-1:0]     map_wkey;
	logic [FLAT_BITS-1:0] map_wval;

	assign key_new  = {pos_q, tc_q, nm_q};
	assign map_wkey = cmd.map_ins_old ? {pos_q, tbl_tc, tbl_nm} : key_new;
	assign map_wval = cmd.map_ins_old ? tbl_flat : next_flat_q[FLAT_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.map_ins_old || cmd.map_ins_new) begin
			key_mem[map_cnt_q[MA_W-1:0]] <= map_wkey;
			val_mem[map_cnt_q[MA_W-1:0]] <= map_wval;
		end
		key_rd_q <= key_mem[scan_idx_q[MA_W-1:0]];
		val_rd_q <= val_mem[scan_idx_q[MA_W-1:0]];
	end

	// status
	always_comb begin
		stat           = '0;
		stat.clr_last  = (clr_idx_q == TBL_AW'(POSITIONS - 1));
		stat.pos_oor   = (OW'(pos_q) >= OW'(POSITIONS));
		stat.mode      = tbl_mode;
		stat.tbl_match = (tbl_tc == tc_q) && (tbl_nm == nm_q);
		stat.room1     = (map_cnt_q < MC_W'(MAP_ENTRIES));
		stat.room2     = (map_cnt_q < MC_W'(MAP_ENTRIES - 1));
		stat.exhausted = next_flat_q[FLAT_BITS];
		stat.scan_hit  = scan_vld_q && (key_rd_q == key_new);
		stat.scan_end  = !scan_vld_q && (scan_idx_q == map_cnt_q);
	end

	// result beat
	logic                 done_q;
	logic [FLAT_BITS-1:0] flat_q;
	logic                 new_q;
	logic [1:0]           status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_ld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			unique case (cmd.res_src)
				vid_pkg::SRC_NONE:  flat_q <= '0;
				vid_pkg::SRC_TABLE: flat_q <= tbl_flat;
				vid_pkg::SRC_MAP:   flat_q <= val_rd_q;
				vid_pkg::SRC_NEXT:  flat_q <= next_flat_q[FLAT_BITS-1:0];
				default:            flat_q <= '0;
			endcase
			new_q    <= cmd.res_new;
			status_q <= cmd.res_status;
		end
	end

	assign done     = done_q;
	assign flat_idx = flat_q;
	assign is_new   = new_q;
	assign status   = status_q;

	`VID_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, map_cnt_q <= MC_W'(MAP_ENTRIES))
	`VID_ASSERT_NOW(a_alloc_room, clk, arst_n, cmd.tbl_wr_cached || cmd.map_ins_new,
		!next_flat_q[FLAT_BITS])
	`VID_ASSERT_NOW(a_ins_room, clk, arst_n, cmd.map_ins_old || cmd.map_ins_new,
		map_cnt_q < MC_W'(MAP_ENTRIES))

endmodule

/* design/vertex_index_deduplicator.sv */
// ---------------------------------------------------------------------------
// vertex_index_deduplicator
// maps (position, texcoord, normal) references to dense flat vertex indices
// ---------------------------------------------------------------------------
// usage
// - command channel: an item (pos_idx, tex_idx, norm_idx)
//   is taken at a clock edge with start high and busy low
// - result channel: one beat per item, done high for exactly one cycle with
//   flat_idx, is_new and status; the receiver cannot stall it
// - steps: a hit in the position table, a first use, or an error found at
//   lookup loads the result in the evaluate step that follows the table
//   read; a mismatch at a cached position adds two map inserts, old then new
// - shared position: the map is scanned one slot per cycle; a hit returns
//   the stored flat index, a miss inserts the new key unless an error stops it
// - busy stays high until the result is loaded, so the next item can follow
//   in the cycle the done beat is shown
// - after reset the position table is cleared one entry per cycle, with busy
//   high; the map and flat counter clear at once
// - status: ok, position out of range, map full, flat indices exhausted;
//   an error leaves all state unchanged and returns flat_idx 0
// ---------------------------------------------------------------------------
module vertex_index_deduplicator #(
	parameter int POSITIONS       = vid_pkg::POSITIONS_DEF,
	parameter int MAP_ENTRIES     = vid_pkg::MAP_ENTRIES_DEF,
	parameter int ATTR_INDEX_BITS = vid_pkg::ATTR_INDEX_BITS_DEF,
	parameter int FLAT_BITS       = vid_pkg::FLAT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [vid_pkg::POS_BITS-1:0]    pos_idx,
	input  logic signed [ATTR_INDEX_BITS:0] tex_idx,
	input  logic signed [ATTR_INDEX_BITS:0] norm_idx,
	output logic                            done,
	output logic [FLAT_BITS-1:0]            flat_idx,
	output logic                            is_new,
	output logic [1:0]                      status
);

	// command and status between sequencer and datapath
	vid_pkg::cmd_t  cmd;
	vid_pkg::stat_t stat;

	// sequencer: clear pass, lookup, scan and insert steps
	vid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// position table, map, counters and result registers
	vid_dpath #(
		.POSITIONS       (POSITIONS),
		.MAP_ENTRIES     (MAP_ENTRIES),
		.ATTR_INDEX_BITS (ATTR_INDEX_BITS),
		.FLAT_BITS       (FLAT_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.pos_idx  (pos_idx),
		.tex_idx  (tex_idx),
		.norm_idx (norm_idx),
		.done     (done),
		.flat_idx (flat_idx),
		.is_new   (is_new),
		.status   (status)
	);

endmodule
